### src/timestamp_to_bcd_parser_defines.svh
// Assertion macros shared by the checker.
`ifndef TIMESTAMP_TO_BCD_PARSER_DEFINES_SVH
`define TIMESTAMP_TO_BCD_PARSER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TS2BCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TS2BCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/ts2bcd_pkg.sv
`timescale 1ns / 1ps

package ts2bcd_pkg;

   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_LOWER_T    = 8'h74;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DIGIT_0    = 8'h30;
   localparam logic [7:0] CH_DIGIT_9    = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CASE_BIT      = 8'h20;
   localparam logic [7:0] SIGN_BIT      = 8'h80;

   localparam logic [2:0] YEAR_DIGITS  = 3'd4;
   localparam logic [2:0] FIELD_DIGITS = 3'd2;

   typedef enum logic [2:0] {
      FS_YEAR   = 3'd0,
      FS_MONTH  = 3'd1,
      FS_DAY    = 3'd2,
      FS_HOUR   = 3'd3,
      FS_MINUTE = 3'd4,
      FS_SECOND = 3'd5,
      FS_ZHOUR  = 3'd6,
      FS_ZMIN   = 3'd7
   } field_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] char_in;
   } step_type;

   typedef struct packed {
      logic        status;
      logic [15:0] year_bcd;
      logic [7:0]  month_bcd;
      logic [7:0]  day_bcd;
      logic [7:0]  hour_bcd;
      logic [7:0]  minute_bcd;
      logic [7:0]  second_bcd;
      logic [7:0]  zone_hour_bcd;
      logic [7:0]  zone_minute_bcd;
   } result_type;

endpackage

### src/timestamp_to_bcd_parser.sv
// Timestamp parser: one character per cycle, BCD fields out on the last one.
// The result of a string reaches the rsp_ ports through the input register, then the
// state update into the result register; the last character waits in the input
// register while the result register holds a result that is not being taken.
// Throughput: one character per cycle; only a stalled result slows the input.
// Reset is synchronous, active high, and clears all parse and handshake state.
`timescale 1ns / 1ps

module timestamp_to_bcd_parser
   import ts2bcd_pkg::*;
#(
   parameter int MAX_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   // character channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_is_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [15:0] rsp_year_bcd,
   output logic [7:0]  rsp_month_bcd,
   output logic [7:0]  rsp_day_bcd,
   output logic [7:0]  rsp_hour_bcd,
   output logic [7:0]  rsp_minute_bcd,
   output logic [7:0]  rsp_second_bcd,
   output logic [7:0]  rsp_zone_hour_bcd,
   output logic [7:0]  rsp_zone_minute_bcd
);

   // Input register: holds one accepted character.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // Result register: one completed string waiting for the consumer.
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;

   logic       req_take;
   logic       out_free;
   logic       step_go;
   step_type   step;
   result_type result;

   // A non-final character never needs the result slot, so it always moves
   // on; the final one waits until the result register is empty or draining.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_go   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || step_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (in_valid_ff && !step_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
      end
   end

   assign step.valid   = step_go;
   assign step.last    = in_last_ff;
   assign step.char_in = in_char_ff;

   // Field state, digit counter, error latch and BCD accumulators.
   ts2bcd_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   always_comb begin
      if (step_go && in_last_ff) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && in_last_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_data_ff.status;
   assign rsp_year_bcd        = out_data_ff.year_bcd;
   assign rsp_month_bcd       = out_data_ff.month_bcd;
   assign rsp_day_bcd         = out_data_ff.day_bcd;
   assign rsp_hour_bcd        = out_data_ff.hour_bcd;
   assign rsp_minute_bcd      = out_data_ff.minute_bcd;
   assign rsp_second_bcd      = out_data_ff.second_bcd;
   assign rsp_zone_hour_bcd   = out_data_ff.zone_hour_bcd;
   assign rsp_zone_minute_bcd = out_data_ff.zone_minute_bcd;

endmodule

### src/ts2bcd_core.sv
`timescale 1ns / 1ps

module ts2bcd_core
   import ts2bcd_pkg::*;
#(
   parameter int MAX_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   output result_type result
);

   field_type          field_ff, field_in;
   logic [2:0]         dl_ff, dl_in;
   logic               err_ff, err_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]        year_ff, year_in;
   logic [7:0]         month_ff, month_in;
   logic [7:0]         day_ff, day_in;
   logic [7:0]         hour_ff, hour_in;
   logic [7:0]         minute_ff, minute_in;
   logic [7:0]         second_ff, second_in;
   logic [7:0]         zhour_ff, zhour_in;
   logic [7:0]         zmin_ff, zmin_in;

   logic [7:0]  ch;
   logic        digit;
   logic        sep_ok;
   logic [2:0]  dl_m1;
   logic [15:0] nib;
   logic        bad;

   always_comb begin
      ch = step.char_in;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         ch = ch | CASE_BIT;
      end
      digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
      dl_m1 = dl_ff - 3'd1;
      // digit lands in nibble (digits_left - 1), MSD first
      nib   = 16'(ch[3:0]) << {dl_m1[1:0], 2'b00};
   end

   always_comb begin
      unique case (field_ff)
         FS_YEAR, FS_MONTH:            sep_ok = (ch == CH_MINUS);
         FS_DAY:                       sep_ok = (ch == CH_LOWER_T) || (ch == CH_UNDERSCORE)
                                                || (ch == CH_SPACE);
         FS_HOUR, FS_MINUTE, FS_ZHOUR: sep_ok = (ch == CH_COLON);
         FS_SECOND, FS_ZMIN:           sep_ok = 1'b0;
      endcase
   end

   always_comb begin
      cnt_in    = (cnt_ff != COUNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
      err_in    = err_ff | (cnt_in > COUNT_W'(MAX_LEN));
      field_in  = field_ff;
      dl_in     = dl_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      zhour_in  = zhour_ff;
      zmin_in   = zmin_ff;
      if (!err_in) begin
         priority if (field_ff == FS_ZHOUR && dl_ff == FIELD_DIGITS && !digit) begin
            // sign characters before the first zone hour digit
            if (ch == CH_MINUS) begin
               zhour_in = zhour_ff | SIGN_BIT;
            end else if (ch != CH_PLUS) begin
               err_in = 1'b1;
            end
         end else if (digit && dl_ff != 3'd0) begin
            unique case (field_ff)
               FS_YEAR:   year_in   = year_ff | nib;
               FS_MONTH:  month_in  = month_ff | nib[7:0];
               FS_DAY:    day_in    = day_ff | nib[7:0];
               FS_HOUR:   hour_in   = hour_ff | nib[7:0];
               FS_MINUTE: minute_in = minute_ff | nib[7:0];
               FS_SECOND: second_in = second_ff | nib[7:0];
               FS_ZHOUR:  zhour_in  = zhour_ff | nib[7:0];
               FS_ZMIN:   zmin_in   = zmin_ff | nib[7:0];
            endcase
            dl_in = dl_m1;
            if (field_ff == FS_SECOND && dl_m1 == 3'd0) begin
               field_in = FS_ZHOUR;
               dl_in    = FIELD_DIGITS;
            end
         end else if (dl_ff == 3'd0 && sep_ok) begin
            field_in = field_type'(field_ff + 3'd1);
            dl_in    = FIELD_DIGITS;
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_comb begin
      bad                    = err_in || (field_in < FS_ZHOUR);
      result.status          = bad;
      result.year_bcd        = bad ? 16'd0 : year_in;
      result.month_bcd       = bad ? 8'd0 : month_in;
      result.day_bcd         = bad ? 8'd0 : day_in;
      result.hour_bcd        = bad ? 8'd0 : hour_in;
      result.minute_bcd      = bad ? 8'd0 : minute_in;
      result.second_bcd      = bad ? 8'd0 : second_in;
      result.zone_hour_bcd   = bad ? 8'd0 : zhour_in;
      result.zone_minute_bcd = bad ? 8'd0 : zmin_in;
   end

   // state goes back to its start value after the last character
   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last)) begin
         field_ff  <= FS_YEAR;
         dl_ff     <= YEAR_DIGITS;
         err_ff    <= 1'b0;
         cnt_ff    <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         zhour_ff  <= '0;
         zmin_ff   <= '0;
      end else if (step.valid) begin
         field_ff  <= field_in;
         dl_ff     <= dl_in;
         err_ff    <= err_in;
         cnt_ff    <= cnt_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         zhour_ff  <= zhour_in;
         zmin_ff   <= zmin_in;
      end
   end

endmodule

### src/ts2bcd_checker.sv
`timescale 1ns / 1ps
`include "timestamp_to_bcd_parser_defines.svh"

module ts2bcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_in,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [15:0] rsp_year_bcd,
   input logic [7:0]  rsp_month_bcd,
   input logic [7:0]  rsp_day_bcd,
   input logic [7:0]  rsp_hour_bcd,
   input logic [7:0]  rsp_minute_bcd,
   input logic [7:0]  rsp_second_bcd,
   input logic [7:0]  rsp_zone_hour_bcd,
   input logic [7:0]  rsp_zone_minute_bcd
);

   logic rsp_zero;
   logic rsp_digits_ok;

   assign rsp_zero = (rsp_year_bcd == 16'd0) && (rsp_month_bcd == 8'd0)
                     && (rsp_day_bcd == 8'd0) && (rsp_hour_bcd == 8'd0)
                     && (rsp_minute_bcd == 8'd0) && (rsp_second_bcd == 8'd0)
                     && (rsp_zone_hour_bcd == 8'd0) && (rsp_zone_minute_bcd == 8'd0);

   // date nibbles, second tens, zone hour ones are decimal
   assign rsp_digits_ok = (rsp_year_bcd[15:12] <= 4'd9) && (rsp_year_bcd[11:8] <= 4'd9)
                          && (rsp_year_bcd[7:4] <= 4'd9) && (rsp_year_bcd[3:0] <= 4'd9)
                          && (rsp_month_bcd[7:4] <= 4'd9) && (rsp_month_bcd[3:0] <= 4'd9)
                          && (rsp_day_bcd[7:4] <= 4'd9) && (rsp_day_bcd[3:0] <= 4'd9)
                          && (rsp_second_bcd[7:4] <= 4'd9)
                          && (rsp_zone_hour_bcd[3:0] <= 4'd9);

   `TS2BCD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year_bcd) && $stable(rsp_status), "stalled result changed")
   `TS2BCD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")
   `TS2BCD_ASSERT(a_bad_zero, rsp_valid && rsp_status |-> rsp_zero, "invalid result carries data")
   `TS2BCD_ASSERT(a_good_bcd, rsp_valid && !rsp_status |-> rsp_digits_ok, "non-decimal BCD digit")

endmodule

bind timestamp_to_bcd_parser ts2bcd_checker u_ts2bcd_checker (.*);

### dv/timestamp_to_bcd_parser_checker.sv
`timescale 1ns / 1ps

module timestamp_to_bcd_parser_checker
   import ts2bcd_pkg::*;
#(
   parameter int MAX_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_status,
   input  logic [15:0] rsp_year_bcd,
   input  logic [7:0]  rsp_month_bcd,
   input  logic [7:0]  rsp_day_bcd,
   input  logic [7:0]  rsp_hour_bcd,
   input  logic [7:0]  rsp_minute_bcd,
   input  logic [7:0]  rsp_second_bcd,
   input  logic [7:0]  rsp_zone_hour_bcd,
   input  logic [7:0]  rsp_zone_minute_bcd,
   output int          mismatch_count,
   output int          open_stamps
);

   // parse state of the string in progress
   field_type          field;
   logic [2:0]         digits_left;
   logic               bad_seen;
   logic [COUNT_W-1:0] chars_taken;
   result_type         fields_acc;

   result_type         expected_stamps[$];
   int                 fail_total = 0;

   task automatic clear_parse();
      field       = FS_YEAR;
      digits_left = YEAR_DIGITS;
      bad_seen    = 1'b0;
      chars_taken = '0;
      fields_acc  = '0;
   endtask

   // most significant digit first: digits_left picks the nibble
   task automatic put_digit(input logic [3:0] d);
      logic [15:0] v;
      int          sh;
      sh = 4 * int'((digits_left - 3'd1) & 3'd3);
      v  = 16'(d) << sh;
      case (field)
         FS_YEAR:   fields_acc.year_bcd        |= v;
         FS_MONTH:  fields_acc.month_bcd       |= v[7:0];
         FS_DAY:    fields_acc.day_bcd         |= v[7:0];
         FS_HOUR:   fields_acc.hour_bcd        |= v[7:0];
         FS_MINUTE: fields_acc.minute_bcd      |= v[7:0];
         FS_SECOND: fields_acc.second_bcd      |= v[7:0];
         FS_ZHOUR:  fields_acc.zone_hour_bcd   |= v[7:0];
         default:   fields_acc.zone_minute_bcd |= v[7:0];
      endcase
      digits_left = digits_left - 3'd1;
   endtask

   function automatic logic separator_ok(input logic [7:0] c);
      case (field)
         FS_YEAR, FS_MONTH:            return c == CH_MINUS;
         FS_DAY:                       return c == CH_LOWER_T || c == CH_UNDERSCORE ||
                                              c == CH_SPACE;
         FS_HOUR, FS_MINUTE, FS_ZHOUR: return c == CH_COLON;
         default:                      return 1'b0;
      endcase
   endfunction

   task automatic parse_char(input logic [7:0] c);
      logic is_digit;
      is_digit = c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
      if (field == FS_ZHOUR && digits_left == FIELD_DIGITS && !is_digit) begin
         // zone sign slot: any number of signs, a minus anywhere sets the flag
         if (c == CH_MINUS)
            fields_acc.zone_hour_bcd |= SIGN_BIT;
         else if (c != CH_PLUS)
            bad_seen = 1'b1;
      end else if (is_digit && digits_left != 3'd0) begin
         put_digit(c[3:0]);
         if (field == FS_SECOND && digits_left == 3'd0) begin
            field       = FS_ZHOUR;
            digits_left = FIELD_DIGITS;
         end
      end else if (digits_left == 3'd0 && separator_ok(c)) begin
         field       = field_type'(field + 3'd1);
         digits_left = FIELD_DIGITS;
      end else begin
         bad_seen = 1'b1;
      end
   endtask

   task automatic take_char(input logic [7:0] raw, input logic last);
      logic [7:0] c;
      result_type r;
      c = raw;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
         c = c | CASE_BIT;
      if (chars_taken != COUNT_MAX)
         chars_taken = chars_taken + 1'b1;
      if (chars_taken > MAX_LEN)
         bad_seen = 1'b1;
      if (!bad_seen)
         parse_char(c);
      if (last) begin
         r        = fields_acc;
         r.status = 1'b0;
         // ended before both second digits, or error: all fields zero
         if (bad_seen || field < FS_ZHOUR) begin
            r        = '0;
            r.status = 1'b1;
         end
         expected_stamps.push_back(r);
         clear_parse();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_total++;
         if (fail_total <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   initial clear_parse();

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         clear_parse();
         expected_stamps.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_stamps.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: result with none expected, status %b",
                           $realtime, rsp_status);
            end else begin
               want = expected_stamps.pop_front();
               check_field("status",          16'(want.status),   16'(rsp_status));
               check_field("year_bcd",        want.year_bcd,       rsp_year_bcd);
               check_field("month_bcd",       want.month_bcd,      rsp_month_bcd);
               check_field("day_bcd",         want.day_bcd,        rsp_day_bcd);
               check_field("hour_bcd",        want.hour_bcd,       rsp_hour_bcd);
               check_field("minute_bcd",      want.minute_bcd,     rsp_minute_bcd);
               check_field("second_bcd",      want.second_bcd,     rsp_second_bcd);
               check_field("zone_hour_bcd",   want.zone_hour_bcd,  rsp_zone_hour_bcd);
               check_field("zone_minute_bcd", want.zone_minute_bcd,
                           rsp_zone_minute_bcd);
            end
         end
         if (req_valid && req_ready === 1'b1)
            take_char(req_char_in, req_is_last);
      end
      mismatch_count <= fail_total;
      open_stamps    <= expected_stamps.size();
   end

endmodule

### dv/timestamp_to_bcd_parser_test.sv
`timescale 1ns / 1ps

module timestamp_to_bcd_parser_test;
   import ts2bcd_pkg::*;

   localparam int MAX_LEN     = 32;
   localparam int CYCLE_LIMIT = 300000;   // far above the slowest legal run
   localparam int PHASE_CHARS = 240;      // minimum random characters per phase

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [15:0] rsp_year_bcd;
   logic [7:0]  rsp_month_bcd;
   logic [7:0]  rsp_day_bcd;
   logic [7:0]  rsp_hour_bcd;
   logic [7:0]  rsp_minute_bcd;
   logic [7:0]  rsp_second_bcd;
   logic [7:0]  rsp_zone_hour_bcd;
   logic [7:0]  rsp_zone_minute_bcd;

   int          mismatch_count;
   int          open_stamps;
   int          cycles = 0;

   // idle odds in percent, changed per phase
   int          send_idle_pct = 26;
   int          recv_idle_pct = 64;

   // characters of the string being built, sent as one burst of transactions
   logic [7:0]  text_q[$];

   timestamp_to_bcd_parser #(.MAX_LEN(MAX_LEN)) dut (.*);

   timestamp_to_bcd_parser_checker #(.MAX_LEN(MAX_LEN)) checker_i (.*);

   always #5 clock = ~clock;

   // result-side backpressure, redrawn every cycle
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timestamp_to_bcd_parser_test failed");
         $finish;
      end
   end

   // One character transaction. Entered and left at a falling edge; valid only
   // drops when an idle gap is drawn, so it is never lowered and raised in one step.
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_is_last <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_char(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endtask

   task automatic add_digits(input int n);
      repeat (n) text_q.push_back(CH_DIGIT_0 + 8'($urandom_range(9)));
   endtask

   task automatic add_sign();
      text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
   endtask

   task automatic send_str(input string s);
      text_q.delete();
      add_str(s);
      send_text();
   endtask

   // YYYY-MM-DD<sep>hh:mm:ss with random digits; the block does no range check
   task automatic add_stamp_body();
      add_digits(4);
      text_q.push_back(CH_MINUS);
      add_digits(2);
      text_q.push_back(CH_MINUS);
      add_digits(2);
      case ($urandom_range(3))
         0:       text_q.push_back(CH_LOWER_T & ~CASE_BIT);
         1:       text_q.push_back(CH_LOWER_T);
         2:       text_q.push_back(CH_UNDERSCORE);
         default: text_q.push_back(CH_SPACE);
      endcase
      add_digits(2);
      text_q.push_back(CH_COLON);
      add_digits(2);
      text_q.push_back(CH_COLON);
      add_digits(2);
   endtask

   // optional [+|-]hh[:mm], often partial; long sign runs push past MAX_LEN
   task automatic add_zone();
      int n;
      if ($urandom_range(5) == 0)
         return;
      repeat ($urandom_range(2)) add_sign();
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(3, 12)) add_sign();
      n = ($urandom_range(3) != 0) ? 2 : $urandom_range(1);
      add_digits(n);
      if (n == 2 && $urandom_range(2) != 0) begin
         text_q.push_back(CH_COLON);
         add_digits($urandom_range(2));
      end
   endtask

   // Mostly well-formed strings; some cut short, corrupted, overlong or pure noise.
   task automatic build_random_stamp();
      int pick;
      int n;
      text_q.delete();
      pick = $urandom_range(99);
      if (pick < 6) begin
         n = $urandom_range(1, 40);
         repeat (n) text_q.push_back(8'($urandom_range(255)));
      end else begin
         add_stamp_body();
         add_zone();
         if (pick < 20) begin
            n = $urandom_range(1, text_q.size() - 1);
            repeat (n) void'(text_q.pop_back());
         end else if (pick < 32) begin
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
         end else if (pick < 36) begin
            // long tails also run the character count into saturation
            repeat ($urandom_range(10, 115)) text_q.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      int sent;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes of digits, all separators, zone forms, length edge
      send_str("0000-00-00T00:00:00");
      send_str("9999-19-39t29:59:99+99:99");
      send_str("2024-02-29_12:34:56-05:30");
      send_str("2024-02-29 12:34:56+-+-+-+-07:00");   // exactly MAX_LEN
      send_str("2024-02-29 12:34:56+-+-+-+-+07:00");  // one over
      send_str("2024-02-29T12:34:5");                 // ends too early
      send_str("2024-02-29T12:34:56-");               // sign only
      send_str("2024-02-29T12:34:56+1:");             // partial zone hour, then colon
      send_str("2024-02-29T12:34:56+12:");
      send_str("2024-02-29X12:34:56Z");               // folded letter, bad separator
      send_str("2024-02-29T12:34:56+12:345");
      text_q.delete();
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      text_q.push_back(8'h80);
      send_text();

      // random: sender busy / receiver busy, then the reverse, then free running
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < PHASE_CHARS) begin
            build_random_stamp();
            sent += text_q.size();
            send_text();
         end
      end
      req_valid <= 1'b0;

      // drain, then leave room for anything stray the block might still emit
      while (open_stamps != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("timestamp_to_bcd_parser_test passed");
      else
         $display("timestamp_to_bcd_parser_test failed");
      $finish;
   end

endmodule

### timestamp_to_bcd_parser.f
+incdir+src
src/ts2bcd_pkg.sv
src/ts2bcd_core.sv
src/timestamp_to_bcd_parser.sv
src/ts2bcd_checker.sv
dv/timestamp_to_bcd_parser_checker.sv
dv/timestamp_to_bcd_parser_test.sv
